@@ hw/rtl/tpdp_pkg.sv @@
// Package for the ternary popcount dot product block.
// Word widths, queue entry type and the popcount helper; no dependencies.
package tpdp_pkg;

  localparam int WORD_W       = 64;
  localparam int VB_W         = 7;
  localparam int CNT_W        = 7;
  localparam int DELTA_W      = 8;
  localparam int MAX_BITS_DEF = 1048576;
  localparam int QUEUE_DEPTH  = 2;

  // One classified word: positive minus negative matches, -64..64
  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic                      last;
  } entry_t;

  // pairwise adder tree, six levels deep
  function automatic logic [CNT_W-1:0] popcount64(input logic [WORD_W-1:0] w);
    logic [1:0] s2  [32];
    logic [2:0] s4  [16];
    logic [3:0] s8  [8];
    logic [4:0] s16 [4];
    logic [5:0] s32 [2];
    for (int k = 0; k < 32; k++) begin
      s2[k] = {1'b0, w[2*k]} + {1'b0, w[2*k+1]};
    end
    for (int k = 0; k < 16; k++) begin
      s4[k] = {1'b0, s2[2*k]} + {1'b0, s2[2*k+1]};
    end
    for (int k = 0; k < 8; k++) begin
      s8[k] = {1'b0, s4[2*k]} + {1'b0, s4[2*k+1]};
    end
    for (int k = 0; k < 4; k++) begin
      s16[k] = {1'b0, s8[2*k]} + {1'b0, s8[2*k+1]};
    end
    for (int k = 0; k < 2; k++) begin
      s32[k] = {1'b0, s16[2*k]} + {1'b0, s16[2*k+1]};
    end
    return {1'b0, s32[0]} + {1'b0, s32[1]};
  endfunction

endpackage

@@ hw/rtl/tpdp_front.sv @@
// Front end: masks the activation word to its valid bits and reduces the
// two planes to one signed match count. Uses tpdp_pkg.
module tpdp_front import tpdp_pkg::*; (
  input  logic [WORD_W-1:0] act_word_i,
  input  logic [WORD_W-1:0] pos_word_i,
  input  logic [WORD_W-1:0] neg_word_i,
  input  logic [VB_W-1:0]   valid_bits_i,
  input  logic              last_word_i,
  output entry_t            entry_o
);

  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] act_m;
  logic [CNT_W-1:0]  pos_cnt;
  logic [CNT_W-1:0]  neg_cnt;

  // counts of 64 and above take the whole word
  assign mask    = valid_bits_i[VB_W-1] ? '1 : ~({WORD_W{1'b1}} << valid_bits_i[VB_W-2:0]);
  assign act_m   = act_word_i & mask;
  assign pos_cnt = popcount64(act_m & pos_word_i);
  assign neg_cnt = popcount64(act_m & neg_word_i);

  assign entry_o.delta = $signed({1'b0, pos_cnt}) - $signed({1'b0, neg_cnt});
  assign entry_o.last  = last_word_i;

endmodule

@@ hw/rtl/tpdp_queue.sv @@
// Short queue between the front end and the accumulator.
// Holds classified words as tpdp_pkg::entry_t; uses tpdp_pkg.
module tpdp_queue import tpdp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   push_ready_o,
  output logic   pop_valid_o,
  output entry_t pop_data_o,
  input  logic   pop_i
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign push_ready_o = count_q < CntW'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // depth is a power of two, so pointers wrap on their own
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/tpdp_back.sv @@
// Back end: saturating accumulator and output register.
// Pops classified words from tpdp_queue; uses tpdp_pkg.
module tpdp_back import tpdp_pkg::*; #(
  parameter int MAX_BITS = MAX_BITS_DEF,
  parameter int SUM_W    = $clog2(MAX_BITS + 1) + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    entry_valid_i,
  input  entry_t                  entry_i,
  output logic                    entry_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [SUM_W-1:0] dot_value_o
);

  localparam logic signed [SUM_W:0] LimPos = (SUM_W + 1)'(MAX_BITS);
  localparam logic signed [SUM_W:0] LimNeg = -LimPos;

  logic signed [SUM_W-1:0] acc_q, acc_d;
  logic signed [SUM_W-1:0] dot_q, dot_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [SUM_W:0]   sum;
  logic signed [SUM_W-1:0] sat;
  logic                    out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  // a last beat waits for room in the output register; others never stall
  assign entry_pop_o = entry_valid_i && (!entry_i.last || out_free);

  assign sum = $signed({acc_q[SUM_W-1], acc_q})
             + $signed({{(SUM_W + 1 - DELTA_W){entry_i.delta[DELTA_W-1]}}, entry_i.delta});

  always_comb begin
    priority if (sum > LimPos) begin
      sat = LimPos[SUM_W-1:0];
    end else if (sum < LimNeg) begin
      sat = LimNeg[SUM_W-1:0];
    end else begin
      sat = sum[SUM_W-1:0];
    end
  end

  always_comb begin
    acc_d       = acc_q;
    dot_d       = dot_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (entry_pop_o) begin
      if (entry_i.last) begin
        acc_d       = '0;
        dot_d       = sat;
        out_valid_d = 1'b1;
      end else begin
        acc_d = sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dot_q <= dot_d;
  end

  assign out_valid_o = out_valid_q;
  assign dot_value_o = dot_q;

`ifndef SYNTHESIS
  a_acc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($signed({acc_q[SUM_W-1], acc_q}) <= LimPos) && ($signed({acc_q[SUM_W-1], acc_q}) >= LimNeg))
    else $error("accumulator outside saturation range");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_pop_o && entry_i.last) |=> (acc_q == '0) && out_valid_q)
    else $error("accumulator not cleared after last beat");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(dot_q))
    else $error("pending result overwritten");

  a_valid_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(entry_pop_o && entry_i.last))
    else $error("result raised without a last beat");
`endif

endmodule

@@ hw/rtl/ternary_popcount_dot_product_top.sv @@
// Ternary popcount dot product, top level.
// Instantiates tpdp_front, tpdp_queue and tpdp_back; uses tpdp_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one beat per 64-element
//   word: activation, positive and negative weight planes, a count of low
//   valid bits (64 and above take the whole word) and a last flag.
//   Output channel (out_valid_o / out_ready_i) returns one beat, dot_value_o,
//   per vector, on the word flagged last. The sum saturates at +/-MAX_BITS.
//   Throughput: one word per cycle, sustained, while the output is taken.
//   Path: the popcount runs in the cycle of acceptance; the two-entry queue and
//   the accumulator add-and-clamp each take one register stage, and a last
//   word can wait in the queue while an earlier result is still pending.
//   Stall: while a result waits, words that are not last keep flowing into
//   the accumulator; a last word holds in the queue until the output
//   register frees, and the queue filling drops in_ready_o.
//   Reset: asynchronous, active low; the accumulator clears, the queue
//   empties and no result is pending.
module ternary_popcount_dot_product_top import tpdp_pkg::*; #(
  parameter int MAX_BITS = MAX_BITS_DEF,
  parameter int SUM_W    = $clog2(MAX_BITS + 1) + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [WORD_W-1:0]       act_word_i,
  input  logic [WORD_W-1:0]       pos_word_i,
  input  logic [WORD_W-1:0]       neg_word_i,
  input  logic [VB_W-1:0]         valid_bits_i,
  input  logic                    last_word_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [SUM_W-1:0] dot_value_o
);

  entry_t front_entry;
  entry_t queue_entry;
  logic   queue_valid;
  logic   queue_pop;

  tpdp_front u_front (
    .act_word_i   (act_word_i),
    .pos_word_i   (pos_word_i),
    .neg_word_i   (neg_word_i),
    .valid_bits_i (valid_bits_i),
    .last_word_i  (last_word_i),
    .entry_o      (front_entry)
  );

  tpdp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_data_i  (front_entry),
    .push_ready_o (in_ready_o),
    .pop_valid_o  (queue_valid),
    .pop_data_o   (queue_entry),
    .pop_i        (queue_pop)
  );

  tpdp_back #(
    .MAX_BITS (MAX_BITS),
    .SUM_W    (SUM_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (queue_valid),
    .entry_i       (queue_entry),
    .entry_pop_o   (queue_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .dot_value_o   (dot_value_o)
  );

endmodule

@@ bench/tpdp_checker.sv @@
// Scoreboard for the ternary popcount dot product block.
// Watches both channels, predicts each dot_value and compares; uses tpdp_pkg.
`timescale 1ns / 1ps

module tpdp_checker import tpdp_pkg::*; #(
  parameter int MAX_BITS = MAX_BITS_DEF,
  parameter int SUM_W    = $clog2(MAX_BITS + 1) + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [WORD_W-1:0]       act_word_i,
  input  logic [WORD_W-1:0]       pos_word_i,
  input  logic [WORD_W-1:0]       neg_word_i,
  input  logic [VB_W-1:0]         valid_bits_i,
  input  logic                    last_word_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [SUM_W-1:0] dot_value_i,
  output int                      err_cnt_o,
  output int                      pending_o
);

  localparam longint SumLimit = MAX_BITS;

  logic signed [SUM_W-1:0] expected_dots[$];
  longint                  dot_acc;

  // positive minus negative matches over the low valid bits of one word
  function automatic longint match_delta(input logic [WORD_W-1:0] act,
                                         input logic [WORD_W-1:0] pos,
                                         input logic [WORD_W-1:0] neg,
                                         input logic [VB_W-1:0]   nvalid);
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] act_m;
    if (nvalid >= WORD_W) mask = '1;
    else                  mask = (64'd1 << nvalid) - 64'd1;
    act_m = act & mask;
    return longint'($countones(act_m & pos)) - longint'($countones(act_m & neg));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [SUM_W-1:0] want;
    longint                  sum;
    if (!rst_ni) begin
      expected_dots.delete();
      dot_acc   <= 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      // result side first: a word accepted now cannot produce a beat this edge
      if (out_valid_i && out_ready_i) begin
        if (expected_dots.size() == 0) begin
          $error("unexpected beat: dot_value actual %0d", dot_value_i);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          want = expected_dots.pop_front();
          if (dot_value_i !== want) begin
            $error("dot_value mismatch: expected %0d, actual %0d", want, dot_value_i);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        sum = dot_acc + match_delta(act_word_i, pos_word_i, neg_word_i, valid_bits_i);
        if (sum > SumLimit)  sum = SumLimit;
        if (sum < -SumLimit) sum = -SumLimit;
        if (last_word_i) begin
          expected_dots.push_back(SUM_W'(sum));
          dot_acc <= 0;
        end else begin
          dot_acc <= sum;
        end
      end
      pending_o <= expected_dots.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
// Top of the bench for ternary_popcount_dot_product_top.
// Drives words and result back-pressure, gives the verdict; uses tpdp_checker, tpdp_pkg.
`timescale 1ns / 1ps

module testbench import tpdp_pkg::*;;

  localparam int SUM_W       = $clog2(MAX_BITS_DEF + 1) + 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_WORDS  = 600;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [WORD_W-1:0]       act_word_i;
  logic [WORD_W-1:0]       pos_word_i;
  logic [WORD_W-1:0]       neg_word_i;
  logic [VB_W-1:0]         valid_bits_i;
  logic                    last_word_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [SUM_W-1:0] dot_value_o;

  int err_cnt;
  int pending_dots;
  int cycle_cnt = 0;
  int words_sent;
  bit quiet;

  ternary_popcount_dot_product_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .act_word_i   (act_word_i),
    .pos_word_i   (pos_word_i),
    .neg_word_i   (neg_word_i),
    .valid_bits_i (valid_bits_i),
    .last_word_i  (last_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .dot_value_o  (dot_value_o)
  );

  tpdp_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .act_word_i   (act_word_i),
    .pos_word_i   (pos_word_i),
    .neg_word_i   (neg_word_i),
    .valid_bits_i (valid_bits_i),
    .last_word_i  (last_word_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .dot_value_i  (dot_value_o),
    .err_cnt_o    (err_cnt),
    .pending_o    (pending_dots)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // result back-pressure
  initial begin
    int hold;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // one beat; returns in the time step of its acceptance
  task automatic send_word(input logic [WORD_W-1:0] act, input logic [WORD_W-1:0] pos,
                           input logic [WORD_W-1:0] neg, input logic [VB_W-1:0] nvalid,
                           input logic is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    act_word_i   <= act;
    pos_word_i   <= pos;
    neg_word_i   <= neg;
    valid_bits_i <= nvalid;
    last_word_i  <= is_last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_dots != 0) @(posedge clk_i);
  endtask

  // well-formed vector: full words, then a last word with a full or partial count;
  // now and then a stray count anywhere in 0..127
  task automatic send_vector(input int nwords);
    logic [WORD_W-1:0] pos;
    logic [WORD_W-1:0] neg;
    logic [VB_W-1:0]   nvalid;
    logic              is_last;
    for (int i = 0; i < nwords; i++) begin
      is_last = (i == nwords - 1);
      if ($urandom_range(0, 9) == 0)  nvalid = VB_W'($urandom_range(0, 127));
      else if (!is_last)              nvalid = VB_W'(WORD_W);
      else if ($urandom_range(0, 1))  nvalid = VB_W'(WORD_W);
      else                            nvalid = VB_W'($urandom_range(0, WORD_W));
      pos = rand_word();
      neg = rand_word();
      if ($urandom_range(0, 1)) neg = neg & ~pos;  // proper ternary: planes disjoint
      send_word(rand_word(), pos, neg, nvalid, is_last);
    end
  endtask

  initial begin
    bit paused;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    act_word_i   = '0;
    pos_word_i   = '0;
    neg_word_i   = '0;
    valid_bits_i = '0;
    last_word_i  = 1'b0;
    words_sent   = 0;
    quiet        = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_word('1, '1, '1, 7'd0, 1'b1);              // empty vector
    send_word('1, '1, '0, 7'd64, 1'b1);             // all positive
    send_word('1, '0, '1, 7'd64, 1'b1);             // all negative
    send_word('1, '1, '1, 7'd64, 1'b1);             // both planes cancel
    send_word('1, '1, '0, 7'd127, 1'b1);            // count above 64
    send_word('1, '0, '1, 7'd65, 1'b1);
    send_word('1, '1, '0, 7'd1, 1'b0);              // partial count mid-vector
    send_word('1, '1, '0, 7'd64, 1'b1);
    send_word('1, '1, '0, 7'd63, 1'b1);
    send_word('0, '1, '1, 7'd64, 1'b1);             // no activations
    send_word({32{2'b01}}, '1, {32{2'b10}}, 7'd64, 1'b1);
    send_word({32{2'b10}}, '1, {32{2'b10}}, 7'd64, 1'b1);
    send_word(64'd1 << 63, 64'd1 << 63, '0, 7'd64, 1'b1);
    send_word(64'd1 << 63, 64'd1 << 63, '0, 7'd63, 1'b1);
    send_word(64'd1, '0, 64'd1, 7'd1, 1'b0);
    send_word('1, '0, '1, 7'd64, 1'b0);
    send_word(64'd1, 64'd1, '0, 7'd0, 1'b1);
    wait_drained();

    words_sent = 0;
    paused     = 1'b0;
    while (words_sent < RAND_WORDS) begin
      quiet = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 15) == 0) send_vector($urandom_range(20, 60));
      else                            send_vector($urandom_range(1, 6));
      if (!paused && words_sent > RAND_WORDS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
